>>> rtl/rre_pkg.sv
// Shared types, constants and helpers of the row echelon reduction block.
`default_nettype none

package rre_pkg;

  // Matrix geometry.
  localparam int MaxRows = 8;
  localparam int MaxCols = 8;
  localparam int Depth   = MaxRows * MaxCols;
  localparam int AddrW   = $clog2(Depth);
  localparam int RIdxW   = $clog2(MaxRows);
  localparam int RCntW   = $clog2(MaxRows + 1);
  localparam int CCntW   = $clog2(MaxCols + 1);

  // Element format and the fixed-point one.
  localparam int ElemW = 32;
  localparam logic signed [ElemW-1:0] OneQ = 32'sh0001_0000;

  // Configuration port.
  localparam int SizeW   = 4;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCols = 2'd1;
  localparam logic [SizeW-1:0]   CfgSizeReset = 4'd8;

  // Queue between loader and reduction engine.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One loaded element with its place in the matrix.
  typedef struct packed {
    logic signed [ElemW-1:0] data;
    logic [RCntW-1:0]        row;
    logic [CCntW-1:0]        col;
    logic                    last;
  } rre_item_t;

  // Effective matrix size.
  typedef struct packed {
    logic [RCntW-1:0] rows;
    logic [CCntW-1:0] cols;
  } rre_size_t;

  function automatic logic [RCntW-1:0] clamp_rows(logic [SizeW-1:0] v);
    logic [RCntW-1:0] res;
    if (v == '0) res = RCntW'(1);
    else if (32'(v) > MaxRows) res = RCntW'(MaxRows);
    else res = RCntW'(v);
    return res;
  endfunction

  function automatic logic [CCntW-1:0] clamp_cols(logic [SizeW-1:0] v);
    logic [CCntW-1:0] res;
    if (v == '0) res = CCntW'(1);
    else if (32'(v) > MaxCols) res = CCntW'(MaxCols);
    else res = CCntW'(v);
    return res;
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(logic [RCntW-1:0] row, logic [CCntW-1:0] col);
    return AddrW'(32'(row) * MaxCols + 32'(col));
  endfunction

endpackage

`default_nettype wire

>>> rtl/reduced_row_echelon.sv
// Gauss-Jordan reduction of a Q16.16 matrix: loader, queue and reduction engine.
// Loading accepts one element per cycle while the queue has room; items queue behind a reduction.
// After the last element, a row update reads, multiplies and writes back each column (the cleared
// column is only written), a division runs per eliminated row and per scaled pivot, and emission
// reads, then outputs each element; the receiver cannot stall, and the memory has one port.
// Reset clears control state and configuration (8 by 8); matrix contents are not cleared.
`default_nettype none

module reduced_row_echelon import rre_pkg::*; (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  output logic                     busy_o,
  input  wire signed [ElemW-1:0]   element_in_i,
  input  wire                      cfg_we_i,
  input  wire        [CfgIdxW-1:0] cfg_idx_i,
  input  wire        [SizeW-1:0]   cfg_data_i,
  output logic                     valid_o,
  output logic signed [ElemW-1:0]  element_out_o,
  output logic                     last_out_o,
  output logic [3:0]               pivot_count_o,
  output logic                     saturated_o
);

  rre_item_t push_item, pop_item;
  rre_size_t size;
  logic      push, pop, full, empty;

  rre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .element_in_i (element_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item),
    .size_o       (size)
  );

  rre_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  rre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .item_i        (pop_item),
    .size_i        (size),
    .valid_o       (valid_o),
    .element_out_o (element_out_o),
    .last_out_o    (last_out_o),
    .pivot_count_o (pivot_count_o),
    .saturated_o   (saturated_o)
  );

endmodule

`default_nettype wire

>>> rtl/rre_front.sv
// Loader front end: configuration registers, load position and item tagging.
`default_nettype none

module rre_front import rre_pkg::*; (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  output logic                     busy_o,
  input  wire signed [ElemW-1:0]   element_in_i,
  input  wire                      cfg_we_i,
  input  wire        [CfgIdxW-1:0] cfg_idx_i,
  input  wire        [SizeW-1:0]   cfg_data_i,
  input  wire                      full_i,
  output logic                     push_o,
  output rre_item_t                item_o,
  output rre_size_t                size_o
);

  logic [SizeW-1:0] rows_cfg_q, cols_cfg_q;
  logic [RCntW-1:0] lr_q;
  logic [CCntW-1:0] lc_q;
  logic             row_end, mat_end;

  // A transaction is taken whenever the queue has room.
  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

  assign size_o.rows = clamp_rows(rows_cfg_q);
  assign size_o.cols = clamp_cols(cols_cfg_q);

  assign row_end = (lc_q == size_o.cols - CCntW'(1));
  assign mat_end = row_end && (lr_q == size_o.rows - RCntW'(1));

  assign item_o.data = element_in_i;
  assign item_o.row  = lr_q;
  assign item_o.col  = lc_q;
  assign item_o.last = mat_end;

  // Writes to the row or column register restart loading; otherwise the position walks row-major.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CfgSizeReset;
      cols_cfg_q <= CfgSizeReset;
      lr_q       <= '0;
      lc_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRows: begin
          rows_cfg_q <= cfg_data_i;
          lr_q       <= '0;
          lc_q       <= '0;
        end
        CfgCols: begin
          cols_cfg_q <= cfg_data_i;
          lr_q       <= '0;
          lc_q       <= '0;
        end
        default: begin
        end
      endcase
    end else if (push_o) begin
      if (mat_end) begin
        lr_q <= '0;
        lc_q <= '0;
      end else if (row_end) begin
        lc_q <= '0;
        lr_q <= lr_q + RCntW'(1);
      end else begin
        lc_q <= lc_q + CCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rre_fifo.sv
// Short queue of tagged elements between loader and reduction engine.
`default_nettype none

module rre_fifo import rre_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  rre_item_t  item_i,
  input  wire        pop_i,
  output rre_item_t  item_o,
  output logic       full_o,
  output logic       empty_o
);

  rre_item_t        buf_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = buf_q[rp_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= item_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + QPtrW'(1);
      if (do_pop)  rp_q <= rp_q + QPtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue fill level beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCntW'(QDepth)) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with fill level");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> $stable(wp_q))
    else $error("queue written while full");

endmodule

`default_nettype wire

>>> rtl/rre_div.sv
// Iterative signed Q16.16 divider with rounding and saturation, one bit a cycle.
`default_nettype none

module rre_div import rre_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire signed [ElemW:0]    num_i,
  input  wire signed [ElemW-1:0]  den_i,
  output logic                    done_o,
  output logic signed [ElemW-1:0] quo_o,
  output logic                    ovf_o
);

  localparam int DvdW = ElemW + 16;
  localparam int CntW = $clog2(DvdW);

  logic [DvdW-1:0]  dvd_q, quo_q;
  logic [ElemW-1:0] dsr_q;
  logic [ElemW:0]   rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q, neg_q, zero_q;

  logic [ElemW:0]   un, rem_sh, rem_sub;
  logic [ElemW-1:0] ud;
  logic             qbit;

  // Operand magnitudes and one restoring step.
  always_comb begin
    un      = num_i[ElemW] ? -num_i : num_i;
    ud      = den_i[ElemW-1] ? ElemW'(-den_i) : ElemW'(den_i);
    rem_sh  = {rem_q[ElemW-1:0], dvd_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    qbit    = (rem_sh >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {un[ElemW-1:0], 16'b0} + DvdW'(ud >> 1);
      dsr_q  <= ud;
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= num_i[ElemW] ^ den_i[ElemW-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= qbit ? rem_sub : rem_sh;
      quo_q <= {quo_q[DvdW-2:0], qbit};
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    quo_o = '0;
    ovf_o = 1'b0;
    if (zero_q) begin
      quo_o = '0;
    end else if (!neg_q) begin
      if (|quo_q[DvdW-1:ElemW-1]) begin
        quo_o = {1'b0, {(ElemW-1){1'b1}}};
        ovf_o = done_q;
      end else begin
        quo_o = quo_q[ElemW-1:0];
      end
    end else begin
      if (quo_q > DvdW'({1'b1, {(ElemW-1){1'b0}}})) begin
        quo_o = {1'b1, {(ElemW-1){1'b0}}};
        ovf_o = done_q;
      end else begin
        quo_o = -quo_q[ElemW-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/rre_back.sv
// Reduction engine: matrix memory, Gauss-Jordan sequencer and result emission.
`default_nettype none

module rre_back import rre_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     empty_i,
  output logic                    pop_o,
  input  rre_item_t               item_i,
  input  rre_size_t               size_i,
  output logic                    valid_o,
  output logic signed [ElemW-1:0] element_out_o,
  output logic                    last_out_o,
  output logic [3:0]              pivot_count_o,
  output logic                    saturated_o
);

  // Sequencer states.
  localparam logic [4:0] StLoad  = 5'd0;
  localparam logic [4:0] StFCol  = 5'd1;
  localparam logic [4:0] StFRd   = 5'd2;
  localparam logic [4:0] StFChk  = 5'd3;
  localparam logic [4:0] StSw0   = 5'd4;
  localparam logic [4:0] StSw1   = 5'd5;
  localparam logic [4:0] StSw2   = 5'd6;
  localparam logic [4:0] StSw3   = 5'd7;
  localparam logic [4:0] StFPiv  = 5'd8;
  localparam logic [4:0] StEChk  = 5'd9;
  localparam logic [4:0] StEE    = 5'd10;
  localparam logic [4:0] StED    = 5'd11;
  localparam logic [4:0] StEDiv  = 5'd12;
  localparam logic [4:0] StU0    = 5'd13;
  localparam logic [4:0] StU1    = 5'd14;
  localparam logic [4:0] StU2    = 5'd15;
  localparam logic [4:0] StBK    = 5'd16;
  localparam logic [4:0] StBRd   = 5'd17;
  localparam logic [4:0] StBP    = 5'd18;
  localparam logic [4:0] StBDiv  = 5'd19;
  localparam logic [4:0] StEmRd  = 5'd20;
  localparam logic [4:0] StEmOut = 5'd21;

  localparam logic signed [49:0] SatHi = 50'sd2147483647;
  localparam logic signed [49:0] SatLo = -50'sd2147483648;

  logic [4:0]              state_q;
  logic [ElemW-1:0]        mem_q [Depth];
  logic signed [ElemW-1:0] rdata_q, tmp_q, e_q, ratio_q;
  logic signed [63:0]      prod_q;
  logic [CCntW-1:0]        pivcol_q [MaxRows];
  logic [CCntW-1:0]        col_q, j_q, pcol_q;
  logic [RCntW-1:0]        next_q, r_q, k_q, found_q, prow_q, piv_q;
  logic                    fwd_q, scale_q, ovf_q;

  logic [RCntW-1:0]        rd_row, wr_row;
  logic [CCntW-1:0]        rd_col, wr_col;
  logic                    wr_en;
  logic signed [ElemW-1:0] wr_data;
  logic                    div_start, div_done, div_ovf;
  logic signed [ElemW:0]   div_num;
  logic signed [ElemW-1:0] div_den, div_quo;

  logic [63:0]             mag, rsum;
  logic [47:0]             rnd;
  logic signed [49:0]      sval, tot;
  logic                    upd_ovf;
  logic signed [ElemW-1:0] upd_val;
  logic                    j_last, em_last;

  rre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  // Rounded product, optional base add and saturation of a row update.
  always_comb begin
    mag  = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    rsum = mag + 64'd32768;
    rnd  = rsum[63:16];
    sval = prod_q[63] ? -$signed({2'b0, rnd}) : $signed({2'b0, rnd});
    tot  = scale_q ? sval : sval + 50'(rdata_q);
    upd_ovf = (tot > SatHi) || (tot < SatLo);
    if (tot > SatHi) upd_val = ElemW'(SatHi);
    else if (tot < SatLo) upd_val = ElemW'(SatLo);
    else upd_val = ElemW'(tot);
  end

  assign j_last  = (j_q == size_i.cols - CCntW'(1));
  assign em_last = j_last && (r_q == size_i.rows - RCntW'(1));

  // Memory port, queue pop and divider launch for each state.
  always_comb begin
    rd_row    = r_q;
    rd_col    = j_q;
    wr_row    = r_q;
    wr_col    = j_q;
    wr_en     = 1'b0;
    wr_data   = '0;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = -(33'(e_q));
    div_den   = rdata_q;
    unique case (state_q)
      StLoad: begin
        pop_o   = ~empty_i;
        wr_en   = ~empty_i;
        wr_row  = item_i.row;
        wr_col  = item_i.col;
        wr_data = item_i.data;
      end
      StFRd: begin
        rd_row = r_q;
        rd_col = col_q;
      end
      StSw0: rd_row = found_q;
      StSw1: rd_row = next_q;
      StSw2: begin
        wr_en   = 1'b1;
        wr_row  = found_q;
        wr_data = rdata_q;
      end
      StSw3: begin
        wr_en   = 1'b1;
        wr_row  = next_q;
        wr_data = tmp_q;
      end
      StEChk: rd_col = pcol_q;
      StEE: begin
        rd_row = prow_q;
        rd_col = pcol_q;
      end
      StED: div_start = 1'b1;
      StBRd: begin
        rd_row = prow_q;
        rd_col = pcol_q;
      end
      StBP: begin
        div_start = (rdata_q != OneQ);
        div_num   = 33'(OneQ);
      end
      StU0: begin
        rd_row = prow_q;
        if (j_q == pcol_q) begin
          wr_en   = 1'b1;
          wr_data = scale_q ? OneQ : '0;
        end
      end
      StU1: rd_row = r_q;
      StU2: begin
        wr_en   = 1'b1;
        wr_data = upd_val;
      end
      default: begin
      end
    endcase
  end

  // Matrix memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[cell_addr(wr_row, wr_col)] <= wr_data;
    rdata_q <= mem_q[cell_addr(rd_row, rd_col)];
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == StSw1) tmp_q <= rdata_q;
    if (state_q == StEE) e_q <= rdata_q;
    if (state_q == StU1) prod_q <= 64'(rdata_q) * 64'(ratio_q);
    if ((state_q == StEDiv || state_q == StBDiv) && div_done) ratio_q <= div_quo;
    if (state_q == StFPiv) pivcol_q[next_q[RIdxW-1:0]] <= col_q;
  end

  // Reduction sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      col_q   <= '0;
      j_q     <= '0;
      pcol_q  <= '0;
      next_q  <= '0;
      r_q     <= '0;
      k_q     <= '0;
      found_q <= '0;
      prow_q  <= '0;
      piv_q   <= '0;
      fwd_q   <= 1'b0;
      scale_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q) inside
        StLoad: begin
          if (!empty_i && item_i.last) begin
            col_q   <= '0;
            next_q  <= '0;
            ovf_q   <= 1'b0;
            state_q <= StFCol;
          end
        end
        StFCol: begin
          if (col_q >= size_i.cols || next_q >= size_i.rows) begin
            piv_q   <= next_q;
            k_q     <= '0;
            state_q <= StBK;
          end else begin
            r_q     <= next_q;
            state_q <= StFRd;
          end
        end
        StFRd: state_q <= StFChk;
        StFChk: begin
          if (rdata_q != '0) begin
            found_q <= r_q;
            j_q     <= '0;
            state_q <= (r_q != next_q) ? StSw0 : StFPiv;
          end else if (r_q + RCntW'(1) >= size_i.rows) begin
            col_q   <= col_q + CCntW'(1);
            state_q <= StFCol;
          end else begin
            r_q     <= r_q + RCntW'(1);
            state_q <= StFRd;
          end
        end
        StSw0: state_q <= StSw1;
        StSw1: state_q <= StSw2;
        StSw2: state_q <= StSw3;
        StSw3: begin
          if (j_last) begin
            state_q <= StFPiv;
          end else begin
            j_q     <= j_q + CCntW'(1);
            state_q <= StSw0;
          end
        end
        StFPiv: begin
          prow_q  <= next_q;
          pcol_q  <= col_q;
          fwd_q   <= 1'b1;
          scale_q <= 1'b0;
          r_q     <= next_q + RCntW'(1);
          state_q <= StEChk;
        end
        StEChk: begin
          if (r_q >= size_i.rows) begin
            if (fwd_q) begin
              next_q  <= next_q + RCntW'(1);
              col_q   <= col_q + CCntW'(1);
              state_q <= StFCol;
            end else begin
              k_q     <= k_q + RCntW'(1);
              state_q <= StBK;
            end
          end else if (r_q == prow_q) begin
            r_q <= r_q + RCntW'(1);
          end else begin
            state_q <= StEE;
          end
        end
        StEE: begin
          if (rdata_q == '0) begin
            r_q     <= r_q + RCntW'(1);
            state_q <= StEChk;
          end else begin
            state_q <= StED;
          end
        end
        StED: state_q <= StEDiv;
        StEDiv: begin
          if (div_done) begin
            ovf_q   <= ovf_q | div_ovf;
            j_q     <= '0;
            state_q <= StU0;
          end
        end
        StU0,
        StU2: begin
          if (state_q == StU0 && j_q != pcol_q) begin
            state_q <= StU1;
          end else begin
            if (state_q == StU2) ovf_q <= ovf_q | upd_ovf;
            if (!j_last) begin
              j_q     <= j_q + CCntW'(1);
              state_q <= StU0;
            end else if (scale_q) begin
              scale_q <= 1'b0;
              r_q     <= '0;
              state_q <= StEChk;
            end else begin
              r_q     <= r_q + RCntW'(1);
              state_q <= StEChk;
            end
          end
        end
        StU1: state_q <= StU2;
        StBK: begin
          if (k_q >= piv_q) begin
            r_q     <= '0;
            j_q     <= '0;
            state_q <= StEmRd;
          end else begin
            prow_q  <= k_q;
            pcol_q  <= pivcol_q[k_q[RIdxW-1:0]];
            fwd_q   <= 1'b0;
            state_q <= StBRd;
          end
        end
        StBRd: state_q <= StBP;
        StBP: begin
          if (rdata_q == OneQ) begin
            scale_q <= 1'b0;
            r_q     <= '0;
            state_q <= StEChk;
          end else begin
            state_q <= StBDiv;
          end
        end
        StBDiv: begin
          if (div_done) begin
            ovf_q   <= ovf_q | div_ovf;
            scale_q <= 1'b1;
            r_q     <= k_q;
            j_q     <= '0;
            state_q <= StU0;
          end
        end
        StEmRd: state_q <= StEmOut;
        StEmOut: begin
          if (em_last) begin
            state_q <= StLoad;
          end else if (j_last) begin
            j_q     <= '0;
            r_q     <= r_q + RCntW'(1);
            state_q <= StEmRd;
          end else begin
            j_q     <= j_q + CCntW'(1);
            state_q <= StEmRd;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Result transaction: valid_o is high for a single cycle per element.
  assign valid_o       = (state_q == StEmOut);
  assign element_out_o = rdata_q;
  assign last_out_o    = valid_o & em_last;
  assign pivot_count_o = 4'(piv_q);
  assign saturated_o   = ovf_q;

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == StLoad))
    else $error("queue drained while reduction in progress");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider finished too early");

  a_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (piv_q <= size_i.rows && 32'(piv_q) <= MaxRows))
    else $error("rank exceeds row count");

  a_emit_ro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmRd || state_q == StEmOut) |-> !wr_en)
    else $error("matrix written during emission");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the reduced_row_echelon block.
`timescale 1ns / 1ps

module tb import rre_pkg::*;;

  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 1500000;
  localparam int DrainWait  = 400;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLast  = 2'd3;
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] elem;
    logic               last;
    logic [3:0]         rank;
    logic               sat;
  } rref_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [ElemW-1:0]  element_in_i;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [SizeW-1:0]         cfg_data_i;
  logic                     valid_o;
  logic signed [ElemW-1:0]  element_out_o;
  logic                     last_out_o;
  logic [3:0]               pivot_count_o;
  logic                     saturated_o;

  reduced_row_echelon u_dut (.*);

  // Predictor state: the matrix being loaded and reduced, and the size registers.
  logic signed [31:0] shadow_mat [64];
  int unsigned        shadow_pivcol [8];
  int unsigned        shadow_loaded;
  logic [3:0]         shadow_rows_reg;
  logic [3:0]         shadow_cols_reg;
  bit                 shadow_ovf;
  int unsigned        shadow_rank;

  rref_result_t pending_rref[$];
  int errors;
  int items_sent;
  int matrices_sent;
  int results_seen;
  longint cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Saturate to 32 bits, noting any clamp.
  function automatic logic signed [31:0] q_sat(longint v);
    if (v > longint'(QMax)) begin
      shadow_ovf = 1'b1;
      return QMax;
    end
    if (v < longint'(QMin)) begin
      shadow_ovf = 1'b1;
      return QMin;
    end
    return v[31:0];
  endfunction

  // Q16.16 product, rounded to nearest with ties away from zero.
  function automatic longint q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    longint mag;
    longint r;
    p   = longint'(a) * longint'(b);
    mag = (p < 0) ? -p : p;
    r   = (mag + 32768) >>> 16;
    return (p < 0) ? -r : r;
  endfunction

  // Q16.16 quotient, rounded the same way and saturated.
  function automatic logic signed [31:0] q_div(longint n, longint d);
    longint un;
    longint ud;
    longint q;
    if (d == 0) return '0;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = ((un <<< 16) + ud / 2) / ud;
    return q_sat(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic int unsigned eff_size(logic [3:0] v);
    if (v == 0) return 1;
    return (v > 8) ? 8 : v;
  endfunction

  // Add ratio times the operand row to the target row; the cleared column becomes zero.
  function automatic void row_axpy(int unsigned tgt, int unsigned src, logic signed [31:0] ratio,
                                   int unsigned clr, int unsigned ncols);
    for (int unsigned j = 0; j < ncols; j++) begin
      if (j == clr) shadow_mat[tgt*8+j] = '0;
      else shadow_mat[tgt*8+j] =
          q_sat(longint'(shadow_mat[tgt*8+j]) + q_mul(shadow_mat[src*8+j], ratio));
    end
  endfunction

  // Gauss-Jordan reduction of the shadow matrix.
  function automatic void gauss_jordan(int unsigned nrows, int unsigned ncols);
    int unsigned nxt;
    int unsigned found;
    int unsigned pc;
    logic signed [31:0] tmp;
    logic signed [31:0] inv;
    logic signed [31:0] e;
    nxt = 0;
    shadow_ovf = 1'b0;
    // Forward pass: pick the pivot, swap it up and clear below.
    for (int unsigned c = 0; c < ncols && nxt < nrows; c++) begin
      found = nrows;
      for (int unsigned r = nxt; r < nrows; r++)
        if (shadow_mat[r*8+c] != 0) begin
          found = r;
          break;
        end
      if (found == nrows) continue;
      if (found != nxt)
        for (int unsigned j = 0; j < ncols; j++) begin
          tmp = shadow_mat[found*8+j];
          shadow_mat[found*8+j] = shadow_mat[nxt*8+j];
          shadow_mat[nxt*8+j] = tmp;
        end
      shadow_pivcol[nxt] = c;
      for (int unsigned r = nxt + 1; r < nrows; r++) begin
        e = shadow_mat[r*8+c];
        if (e == 0) continue;
        row_axpy(r, nxt, q_div(-longint'(e), shadow_mat[nxt*8+c]), c, ncols);
      end
      nxt++;
    end
    shadow_rank = nxt;
    // Backward pass: normalise each pivot row, then clear its column elsewhere.
    for (int unsigned k = 0; k < shadow_rank; k++) begin
      pc = shadow_pivcol[k];
      if (shadow_mat[k*8+pc] != OneQ) begin
        inv = q_div(longint'(OneQ), shadow_mat[k*8+pc]);
        for (int unsigned j = 0; j < ncols; j++)
          shadow_mat[k*8+j] = (j == pc) ? OneQ : q_sat(q_mul(shadow_mat[k*8+j], inv));
      end
      for (int unsigned r = 0; r < nrows; r++) begin
        e = shadow_mat[r*8+pc];
        if (r == k || e == 0) continue;
        row_axpy(r, k, q_div(-longint'(e), shadow_mat[k*8+pc]), pc, ncols);
      end
    end
  endfunction

  // Take one accepted element; on the last one, reduce and queue the results.
  function automatic void load_element(logic signed [31:0] v);
    int unsigned nr;
    int unsigned nc;
    rref_result_t res;
    nr = eff_size(shadow_rows_reg);
    nc = eff_size(shadow_cols_reg);
    if (shadow_loaded >= nr * nc) shadow_loaded = 0;
    shadow_mat[(shadow_loaded / nc) * 8 + shadow_loaded % nc] = v;
    shadow_loaded++;
    if (shadow_loaded < nr * nc) return;
    shadow_loaded = 0;
    gauss_jordan(nr, nc);
    for (int unsigned r = 0; r < nr; r++)
      for (int unsigned c = 0; c < nc; c++) begin
        res.elem = shadow_mat[r*8+c];
        res.last = (r == nr - 1) && (c == nc - 1);
        res.rank = shadow_rank[3:0];
        res.sat  = shadow_ovf;
        pending_rref = {pending_rref, res};
      end
  endfunction

  // Result checker: each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    rref_result_t want;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_rref.size() == 0) begin
        $display("%0t: unexpected result elem=%h last=%b rank=%0d sat=%b", $time,
                 element_out_o, last_out_o, pivot_count_o, saturated_o);
        errors++;
      end else begin
        want = pending_rref.pop_front();
        if (element_out_o !== want.elem) begin
          $display("%0t: element expected %h actual %h", $time, want.elem, element_out_o);
          errors++;
        end
        if (last_out_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_out_o);
          errors++;
        end
        if (pivot_count_o !== want.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, want.rank, pivot_count_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_rref.size());
      $display("[reduced_row_echelon] ERROR");
      $finish;
    end
  end

  // Send one element as a transaction; entered and left at a falling edge.
  task automatic send_element(logic signed [31:0] v);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    element_in_i <= v;
    do @(posedge clk_i); while (busy_o);
    load_element(v);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every expected result has come and the block has settled.
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_rref.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [3:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRows) begin
      shadow_rows_reg = val;
      shadow_loaded = 0;
    end else if (idx == CfgCols) begin
      shadow_cols_reg = val;
      shadow_loaded = 0;
    end
  endtask

  task automatic set_shape(logic [3:0] nr, logic [3:0] nc);
    drain_results();
    write_size(CfgRows, nr);
    write_size(CfgCols, nc);
  endtask

  // Random element: mostly small whole or fractional values, some zeros and extremes.
  function automatic logic signed [31:0] rand_element();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      5, 6:    return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      7:       return ($urandom_range(0, 1) != 0) ? QMax : QMin;
      default: return $urandom();
    endcase
  endfunction

  // Send a whole matrix at the current shape; some rows repeat earlier ones to cut the rank.
  task automatic send_random_matrix();
    logic signed [31:0] m [64];
    int unsigned nr;
    int unsigned nc;
    int unsigned dup;
    nr = eff_size(shadow_rows_reg);
    nc = eff_size(shadow_cols_reg);
    for (int unsigned r = 0; r < nr; r++) begin
      dup = (r > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, r - 1) : 8;
      for (int unsigned c = 0; c < nc; c++)
        m[r*8+c] = (dup < 8) ? m[dup*8+c] : rand_element();
    end
    for (int unsigned r = 0; r < nr; r++)
      for (int unsigned c = 0; c < nc; c++) send_element(m[r*8+c]);
    matrices_sent++;
  endtask

  // Extremes, saturation, a row swap, unit pivots, a zero matrix and two 1 by 1 cases.
  task automatic test_directed();
    set_shape(4'd2, 4'd2);
    send_element(32'sh0000_0001);
    send_element(QMax);
    send_element(QMin);
    send_element(QMin);
    set_shape(4'd3, 4'd3);
    send_element('0);
    send_element(32'sh0002_0000);
    send_element(32'sh0001_0000);
    send_element(OneQ);
    send_element(32'sh0003_0000);
    send_element(-32'sh0000_8000);
    send_element(32'sh0002_0000);
    send_element(32'sh0006_0000);
    send_element(-32'sh0001_0000);
    set_shape(4'd1, 4'd3);
    repeat (3) send_element('0);
    set_shape(4'd0, 4'd0);
    send_element(QMin);
    send_element(-32'sh0000_0001);
    set_shape(4'd2, 4'd3);
    repeat (2) begin
      send_element(OneQ);
      send_element(32'sh0002_0000);
      send_element(-32'sh0001_0000);
    end
    matrices_sent += 6;
  endtask

  // Load restart on a register write, the unused indexes and oversize values.
  task automatic test_config();
    set_shape(4'd2, 4'd2);
    send_element(32'sh1234_5678);
    send_element(-32'sh0100_0000);
    drain_results();
    write_size(CfgCols, 4'd3);
    write_size(CfgSpare, 4'd1);
    write_size(CfgLast, 4'd15);
    send_random_matrix();
    set_shape(4'd15, 4'd15);
    send_random_matrix();
    set_shape(4'd8, 4'd1);
    send_random_matrix();
    set_shape(4'd1, 4'd8);
    send_random_matrix();
  endtask

  // Random matrices, mostly small; the shape changes every few matrices.
  task automatic test_random();
    int unsigned nr;
    int unsigned nc;
    int big_left;
    big_left = 3;
    while (items_sent < 410) begin
      if (big_left > 0 && $urandom_range(0, 9) == 0) begin
        nr = $urandom_range(6, 8);
        nc = $urandom_range(6, 8);
        big_left--;
      end else begin
        nr = $urandom_range(1, 4);
        nc = $urandom_range(1, 5);
      end
      set_shape(nr[3:0], nc[3:0]);
      repeat ($urandom_range(1, 4)) begin
        if (items_sent < 410) send_random_matrix();
        if ($urandom_range(0, 5) == 0) drain_results();
      end
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    matrices_sent = 0;
    results_seen = 0;
    cycles = 0;
    shadow_loaded = 0;
    shadow_rank = 0;
    shadow_ovf = 1'b0;
    shadow_rows_reg = CfgSizeReset;
    shadow_cols_reg = CfgSizeReset;
    rst_ni = 1'b0;
    start_i = 1'b0;
    element_in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgRows;
    cfg_data_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config();
    test_random();
    drain_results();

    $display("Sent %0d elements in %0d matrices of sizes 1x1 to 8x8; checked %0d results.",
             items_sent, matrices_sent, results_seen);
    $display("Covered extremes, saturation, swaps, rank loss and size register clamping.");
    if (errors == 0) begin
      $display("[reduced_row_echelon] OK");
    end else begin
      $display("[reduced_row_echelon] ERROR");
    end
    $finish;
  end

endmodule
